@@ rtl/modbus_frame_trailer_encoder_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the Modbus frame trailer encoder checker.
// Both macros sample on clk and are disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MODBUS_FRAME_TRAILER_ENCODER_ASSERT_SVH
`define MODBUS_FRAME_TRAILER_ENCODER_ASSERT_SVH

// Same-cycle implication
`define MFTE_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mfte assertion failed");

// Next-cycle implication
`define MFTE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mfte assertion failed");

`endif

@@ rtl/mfte_pkg.sv @@
// ----------------------------------------------------------------------------
// mfte_pkg
// Shared types, constants and helper functions of the Modbus frame encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mfte_pkg;

	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'hA001;
	localparam logic [7:0]  HEX_LETTER = 8'h37;
	localparam logic [7:0]  HEX_DIGIT  = 8'h30;
	localparam logic [7:0]  CHAR_CR    = 8'h0D;
	localparam logic [7:0]  CHAR_LF    = 8'h0A;
	localparam logic [7:0]  CHAR_COLON = 8'h3A;

	// Queue between front and back end
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Configuration register map
	localparam int          PADDR_W        = 3;
	localparam logic        REG_ASCII_MODE = 1'b0;

	// One classified byte handed from the front end to the back end
	typedef struct packed {
		logic        ascii;   // ASCII framing for this byte
		logic        colon;   // lead the byte with ':'
		logic        last;    // append the trailer
		logic [7:0]  data;    // payload byte
		logic [15:0] check;   // RTU: CRC; ASCII: LRC in the low byte
	} job_t;

	// One CRC-16 update over a whole byte, LSB first
	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	// Upper-case hex character of a nibble
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] n;
		n = {4'h0, nib};
		return (nib > 4'd9) ? (n + HEX_LETTER) : (n + HEX_DIGIT);
	endfunction

endpackage

`default_nettype wire

@@ rtl/mfte_front.sv @@
// ----------------------------------------------------------------------------
// mfte_front
// Accepts payload bytes, keeps the running CRC-16 and LRC sum, and classifies
// each byte into a job for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mfte_front
	import mfte_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       ascii_mode,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] frame_byte,
	input  wire logic       frame_end,
	input  wire logic       q_full,
	output logic            q_push,
	output job_t            q_job
);

	logic [15:0] crc_q;
	logic [7:0]  lrc_q;
	logic        start_q;
	logic [15:0] crc_next;
	logic [7:0]  lrc_next;
	logic [7:0]  lrc_neg;

	// Stall while the queue has no room
	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	// Fold the new byte into both checks
	assign crc_next = crc_update(crc_q, frame_byte);
	assign lrc_next = lrc_q + frame_byte;
	assign lrc_neg  = 8'h00 - lrc_next;

	// Build the job word
	always_comb begin
		q_job.ascii = ascii_mode;
		q_job.colon = ascii_mode && start_q;
		q_job.last  = frame_end;
		q_job.data  = frame_byte;
		q_job.check = ascii_mode ? {8'h00, lrc_neg} : crc_next;
	end

	// Advance frame state; reset it after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= CRC_INIT;
			lrc_q   <= 8'h00;
			start_q <= 1'b1;
		end else if (q_push) begin
			if (frame_end) begin
				crc_q   <= CRC_INIT;
				lrc_q   <= 8'h00;
				start_q <= 1'b1;
			end else begin
				crc_q   <= crc_next;
				lrc_q   <= lrc_next;
				start_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/mfte_queue.sv @@
// ----------------------------------------------------------------------------
// mfte_queue
// Short job queue between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mfte_queue
	import mfte_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	output logic      full,
	input  wire logic pop,
	output logic      head_valid,
	output job_t      head_job
);

	job_t               mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_push;
	logic               do_pop;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// Store the pushed word
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/mfte_back.sv @@
// ----------------------------------------------------------------------------
// mfte_back
// Steps through each job, emitting one line byte per cycle unless stalled,
// to an output register: data and CRC in RTU; ':', hex, LRC, CR, LF in ASCII.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mfte_back
	import mfte_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       q_valid,
	input  wire job_t       q_job,
	output logic            q_pop,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      line_byte,
	output logic            line_end
);

	// RTU steps
	localparam logic [2:0] RS_DATA   = 3'd0;
	localparam logic [2:0] RS_CRC_LO = 3'd1;
	localparam logic [2:0] RS_CRC_HI = 3'd2;
	// ASCII steps
	localparam logic [2:0] AS_COLON  = 3'd0;
	localparam logic [2:0] AS_HI     = 3'd1;
	localparam logic [2:0] AS_LO     = 3'd2;
	localparam logic [2:0] AS_LRC_HI = 3'd3;
	localparam logic [2:0] AS_LRC_LO = 3'd4;
	localparam logic [2:0] AS_CR     = 3'd5;
	localparam logic [2:0] AS_LF     = 3'd6;

	job_t       job_q;
	logic       busy_q;
	logic [2:0] step_q;
	logic       out_valid_q;
	logic [7:0] line_byte_q;
	logic       line_end_q;
	logic       out_load;
	logic       emit;
	logic       at_last;
	logic [2:0] last_step;
	logic [2:0] first_step;
	logic [7:0] byte_c;
	logic       end_c;

	assign out_valid = out_valid_q;
	assign line_byte = line_byte_q;
	assign line_end  = line_end_q;

	// Output register takes a word when empty or drained
	assign out_load = !out_valid_q || !out_stall;
	assign emit     = busy_q && out_load;

	// Step range of the current and the next job
	always_comb begin
		if (job_q.ascii) begin
			last_step = job_q.last ? AS_LF : AS_LO;
		end else begin
			last_step = job_q.last ? RS_CRC_HI : RS_DATA;
		end
		if (q_job.ascii) begin
			first_step = q_job.colon ? AS_COLON : AS_HI;
		end else begin
			first_step = RS_DATA;
		end
	end

	assign at_last = (step_q == last_step);
	assign q_pop   = q_valid && (!busy_q || (emit && at_last));

	// Decode the line byte of the current step
	always_comb begin
		byte_c = job_q.data;
		end_c  = 1'b0;
		if (job_q.ascii) begin
			unique case (step_q)
				AS_COLON:  byte_c = CHAR_COLON;
				AS_HI:     byte_c = hex_char(job_q.data[7:4]);
				AS_LO:     byte_c = hex_char(job_q.data[3:0]);
				AS_LRC_HI: byte_c = hex_char(job_q.check[7:4]);
				AS_LRC_LO: byte_c = hex_char(job_q.check[3:0]);
				AS_CR:     byte_c = CHAR_CR;
				AS_LF: begin
					byte_c = CHAR_LF;
					end_c  = 1'b1;
				end
				default:   byte_c = job_q.data;
			endcase
		end else begin
			unique case (step_q)
				RS_DATA:   byte_c = job_q.data;
				RS_CRC_LO: byte_c = job_q.check[7:0];
				RS_CRC_HI: begin
					byte_c = job_q.check[15:8];
					end_c  = 1'b1;
				end
				default:   byte_c = job_q.data;
			endcase
		end
	end

	// Hold the current job
	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_job;
		end
	end

	// Sequence steps; take the next job right after the last step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (q_pop) begin
			busy_q <= 1'b1;
			step_q <= first_step;
		end else if (emit) begin
			if (at_last) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= step_q + 3'd1;
			end
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= emit;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			line_byte_q <= byte_c;
			line_end_q  <= end_c;
		end
	end

endmodule

`default_nettype wire

@@ rtl/modbus_frame_trailer_encoder.sv @@
// ----------------------------------------------------------------------------
// modbus_frame_trailer_encoder
// Modbus serial framer: RTU with CRC-16 or ASCII with LRC.
// ----------------------------------------------------------------------------
// Bytes of a frame enter on the in channel, frame_end marking the last one,
// and line bytes leave on the out channel, line_end marking the last byte of
// the frame. ascii_mode (APB register at address 0) selects RTU or ASCII and
// must be written only while the block is idle; the block itself does not
// enforce this. The back end emits one line byte per clock unless stalled: in
// RTU one line byte per byte and three on the last byte; in ASCII two line
// bytes per byte, one more on the first byte for the ':' and four more on the
// last for the LRC, CR and LF. The front end computes the CRC and LRC in the
// accept cycle and hands classified bytes to the back end through a two-entry
// queue, so input is taken while earlier bytes are still being sent; first
// output passes through the queue, the job register and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module modbus_frame_trailer_encoder
	import mfte_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	// Configuration port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	// Input words
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [7:0]         frame_byte,
	input  wire logic               frame_end,
	// Output words
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [7:0]              line_byte,
	output logic                    line_end
);

	logic ascii_mode_q;
	logic reg_sel;
	logic q_full;
	logic q_push;
	job_t push_job;
	logic q_pop;
	logic q_valid;
	job_t head_job;

	// Register decode
	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_ASCII_MODE);
	assign prdata  = reg_sel ? {31'h0, ascii_mode_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ascii_mode_q <= 1'b0;
		end else if (psel && penable && pwrite && reg_sel) begin
			ascii_mode_q <= pwdata[0];
		end
	end

	mfte_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.ascii_mode (ascii_mode_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.frame_byte (frame_byte),
		.frame_end  (frame_end),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_job      (push_job)
	);

	mfte_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_job   (head_job)
	);

	mfte_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_job     (head_job),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.line_byte (line_byte),
		.line_end  (line_end)
	);

endmodule

`default_nettype wire

@@ rtl/mfte_checker.sv @@
// ----------------------------------------------------------------------------
// mfte_checker
// Port-level checks of the Modbus frame encoder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "modbus_frame_trailer_encoder_assert.svh"

module mfte_checker
	import mfte_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               psel,
	input wire logic               penable,
	input wire logic               pwrite,
	input wire logic [PADDR_W-1:0] paddr,
	input wire logic [31:0]        pwdata,
	input wire logic [31:0]        prdata,
	input wire logic               pready,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic [7:0]         frame_byte,
	input wire logic               frame_end,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic [7:0]         line_byte,
	input wire logic               line_end
);

	logic mode_q;
	logic out_acc;

	// Track the mode from register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_ASCII_MODE)) begin
			mode_q <= pwdata[0];
		end
	end

	assign out_acc = out_valid && !out_stall;

	// A stalled word holds
	`MFTE_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(line_byte) && $stable(line_end))

	// A stalled payload word holds
	`MFTE_ASSERT_NEXT(a_in_hold, in_valid && in_stall,
		in_valid && $stable(frame_byte) && $stable(frame_end))

	// An ASCII frame ends on LF
	`MFTE_ASSERT_IMP(a_ascii_lf, out_acc && line_end && mode_q, line_byte == CHAR_LF)

	// The mode register reads back one bit
	`MFTE_ASSERT_IMP(a_prdata_narrow, psel && !pwrite, prdata[31:1] == 31'h0)

endmodule

bind modbus_frame_trailer_encoder mfte_checker u_checker (.*);

`default_nettype wire
